[hdl/fedl_pkg.sv]
package fedl_pkg;

    // delay line geometry
    localparam int LINE_DEPTH   = 8192;
    localparam int ADDR_W       = $clog2(LINE_DEPTH);
    localparam int MAX_CHANNELS = 2;
    localparam int CH_W         = $clog2(MAX_CHANNELS + 1);

    // field widths
    localparam int SAMPLE_W = 16;
    localparam int FRAMES_W = 14;
    localparam int CHCFG_W  = 2;
    localparam int FB_W     = 8;

    // frame pointer times channel count
    localparam int PROD_W = FRAMES_W + CH_W;

    // mixer arithmetic
    localparam int WEIGHT_SHIFT = 7;
    localparam logic [FB_W-1:0] WEIGHT_ONE = FB_W'(1 << WEIGHT_SHIFT);
    localparam int MIX_W = SAMPLE_W + 3 + WEIGHT_SHIFT;

    // result buffer
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // configuration port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    localparam sample_t SAMPLE_MAX = sample_t'(16'sh7fff);
    localparam sample_t SAMPLE_MIN = sample_t'(16'sh8000);

    typedef enum logic [1:0] {
        REG_DELAY_FRAMES    = 2'd0,
        REG_CHANNEL_COUNT   = 2'd1,
        REG_FEEDBACK_FACTOR = 2'd2
    } reg_index_t;

    typedef struct packed {
        sample_t               sample_in;
        logic                  block_start;
        logic [FRAMES_W-1:0]   block_frames;
    } in_item_t;

    typedef struct packed {
        sample_t sample_out;
        logic    bypassed;
    } out_item_t;

endpackage

[hdl/fedl_mix.sv]
module fedl_mix (
    input  fedl_pkg::sample_t           stored,
    input  fedl_pkg::sample_t           live,
    input  logic [fedl_pkg::FB_W-1:0]   fb,
    output fedl_pkg::sample_t           mix
);

    logic signed [fedl_pkg::SAMPLE_W:0]    diff;
    logic signed [fedl_pkg::MIX_W-1:0]     prod;
    logic signed [fedl_pkg::MIX_W-1:0]     scaled;
    logic signed [fedl_pkg::MIX_W-1:0]     sum;
    logic signed [fedl_pkg::MIX_W-1:0]     adj;
    logic signed [fedl_pkg::MIX_W-1:0]     quot;

    // stored*fb + live*(128-fb) == live*128 + (stored-live)*fb
    assign diff   = {stored[fedl_pkg::SAMPLE_W-1], stored} - {live[fedl_pkg::SAMPLE_W-1], live};
    assign prod   = diff * $signed({1'b0, fb});
    assign scaled = fedl_pkg::MIX_W'(live) <<< fedl_pkg::WEIGHT_SHIFT;
    assign sum    = prod + scaled;

    // divide by 128 rounding toward zero
    assign adj  = sum[fedl_pkg::MIX_W-1]
                ? sum + fedl_pkg::MIX_W'((1 << fedl_pkg::WEIGHT_SHIFT) - 1)
                : sum;
    assign quot = adj >>> fedl_pkg::WEIGHT_SHIFT;

    // clamp to sample range
    always_comb
    begin
        if (quot > fedl_pkg::MIX_W'(fedl_pkg::SAMPLE_MAX))
            mix = fedl_pkg::SAMPLE_MAX;
        else if (quot < fedl_pkg::MIX_W'(fedl_pkg::SAMPLE_MIN))
            mix = fedl_pkg::SAMPLE_MIN;
        else
            mix = fedl_pkg::sample_t'(quot[fedl_pkg::SAMPLE_W-1:0]);
    end

endmodule

[hdl/fedl_out_fifo.sv]
module fedl_out_fifo (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    input  fedl_pkg::out_item_t               push_data,
    input  logic                              pop,
    output fedl_pkg::out_item_t               pop_data,
    output logic                              not_empty,
    output logic [fedl_pkg::FIFO_CNT_W-1:0]   count
);

    fedl_pkg::out_item_t                 entry_reg [fedl_pkg::FIFO_DEPTH];
    logic [fedl_pkg::FIFO_PTR_W-1:0]     wr_ptr_reg;
    logic [fedl_pkg::FIFO_PTR_W-1:0]     rd_ptr_reg;
    logic [fedl_pkg::FIFO_CNT_W-1:0]     count_reg;
    logic [fedl_pkg::FIFO_CNT_W-1:0]     count_next;
    logic                                do_pop;

    assign not_empty = (count_reg != '0);
    assign do_pop    = pop && not_empty;
    assign pop_data  = entry_reg[rd_ptr_reg];
    assign count     = count_reg;

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (!push && do_pop)
            count_next = count_reg - 1'b1;
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

[hdl/feedback_echo_delay_line_core.sv]
// channel   direction  handshake                      payload
// in        request    in_valid / in_ready            in_data   (fedl_pkg::in_item_t)
// out       result     out_valid / out_ready          out_data  (fedl_pkg::out_item_t)
// config    write/read psel penable pwrite pready     paddr pwdata prdata (32 bit)
//
// one sample per cycle sustained while the output keeps up; the delay line is read at accept and
// written back in the next cycle, a bypass register covers back-to-back hits
// result passes the mix stage register, then a four-entry result buffer
// after reset the delay line is cleared one entry per cycle, all 8192 entries, with
// in_ready low; configuration writes are taken during that time
// a stalled output fills the buffer, then in_ready drops until it drains
module feedback_echo_delay_line_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  fedl_pkg::in_item_t                    in_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output fedl_pkg::out_item_t                   out_data,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [fedl_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [fedl_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [fedl_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                  pready
);

    // configuration registers
    logic [fedl_pkg::FRAMES_W-1:0]  delay_frames_reg;
    logic [fedl_pkg::CHCFG_W-1:0]   channel_count_reg;
    logic [fedl_pkg::FB_W-1:0]      feedback_factor_reg;
    fedl_pkg::reg_index_t           reg_index;
    logic                           cfg_write;

    // effective settings
    logic [fedl_pkg::FB_W-1:0]      fb_eff;
    logic [fedl_pkg::CH_W-1:0]      ch_eff;

    // block state
    logic [fedl_pkg::FRAMES_W-1:0]  line_ptr_reg;
    logic                           bypass_reg;
    logic [fedl_pkg::ADDR_W-1:0]    sample_addr_reg;

    // accept stage
    logic                           accept;
    logic                           start_bypass;
    logic [fedl_pkg::FRAMES_W:0]    ptr_sum;
    logic                           rewind;
    logic [fedl_pkg::FRAMES_W-1:0]  ptr_base;
    logic [fedl_pkg::PROD_W-1:0]    base_prod;
    logic [fedl_pkg::ADDR_W-1:0]    base_addr;
    logic                           item_bypass;
    logic [fedl_pkg::ADDR_W-1:0]    item_addr;

    // mix stage
    logic                           s1_valid_reg;
    logic                           s1_bypass_reg;
    logic [fedl_pkg::ADDR_W-1:0]    s1_addr_reg;
    fedl_pkg::sample_t              s1_live_reg;
    fedl_pkg::sample_t              stored;
    fedl_pkg::sample_t              mix;
    fedl_pkg::out_item_t            s1_result;

    // memory and its write bypass
    logic [fedl_pkg::SAMPLE_W-1:0]  line_mem [fedl_pkg::LINE_DEPTH];
    fedl_pkg::sample_t              rd_data_reg;
    logic                           wr_en;
    logic [fedl_pkg::ADDR_W-1:0]    wr_addr;
    fedl_pkg::sample_t              wr_data;
    logic                           fwd_valid_reg;
    logic [fedl_pkg::ADDR_W-1:0]    fwd_addr_reg;
    fedl_pkg::sample_t              fwd_data_reg;

    // clearing pass
    logic [fedl_pkg::ADDR_W:0]      clear_cnt_reg;
    logic                           clear_done;

    // result buffer
    logic [fedl_pkg::FIFO_CNT_W-1:0] fifo_count;
    logic [fedl_pkg::FIFO_CNT_W:0]   inflight;

    // configuration port
    assign pready    = 1'b1;
    assign reg_index = fedl_pkg::reg_index_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_frames_reg    <= fedl_pkg::FRAMES_W'(4096);
            channel_count_reg   <= fedl_pkg::CHCFG_W'(1);
            feedback_factor_reg <= fedl_pkg::FB_W'(64);
        end
        else if (cfg_write)
        begin
            case (reg_index)
                fedl_pkg::REG_DELAY_FRAMES:
                    delay_frames_reg <= pwdata[fedl_pkg::FRAMES_W-1:0];
                fedl_pkg::REG_CHANNEL_COUNT:
                    channel_count_reg <= pwdata[fedl_pkg::CHCFG_W-1:0];
                fedl_pkg::REG_FEEDBACK_FACTOR:
                    feedback_factor_reg <= pwdata[fedl_pkg::FB_W-1:0];
                default:
                    ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            fedl_pkg::REG_DELAY_FRAMES:    prdata = fedl_pkg::APB_DATA_W'(delay_frames_reg);
            fedl_pkg::REG_CHANNEL_COUNT:   prdata = fedl_pkg::APB_DATA_W'(channel_count_reg);
            fedl_pkg::REG_FEEDBACK_FACTOR: prdata = fedl_pkg::APB_DATA_W'(feedback_factor_reg);
            default:                       prdata = '0;
        endcase
    end

    // clamp feedback and channel count
    assign fb_eff = (feedback_factor_reg > fedl_pkg::WEIGHT_ONE)
                  ? fedl_pkg::WEIGHT_ONE : feedback_factor_reg;

    always_comb
    begin
        if (channel_count_reg == '0)
            ch_eff = fedl_pkg::CH_W'(1);
        else if (32'(channel_count_reg) > fedl_pkg::MAX_CHANNELS)
            ch_eff = fedl_pkg::CH_W'(fedl_pkg::MAX_CHANNELS);
        else
            ch_eff = fedl_pkg::CH_W'(channel_count_reg);
    end

    // block start decision and sample address
    assign accept       = in_valid && in_ready;
    assign start_bypass = (fb_eff == '0) || (in_data.block_frames > delay_frames_reg);
    assign ptr_sum      = {1'b0, line_ptr_reg} + {1'b0, in_data.block_frames};
    assign rewind       = ptr_sum > {1'b0, delay_frames_reg};
    assign ptr_base     = rewind ? '0 : line_ptr_reg;
    assign base_prod    = fedl_pkg::PROD_W'(ptr_base) * fedl_pkg::PROD_W'(ch_eff);
    assign base_addr    = fedl_pkg::ADDR_W'(base_prod);
    assign item_bypass  = in_data.block_start ? start_bypass : bypass_reg;
    assign item_addr    = (in_data.block_start && !start_bypass) ? base_addr : sample_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_ptr_reg    <= '0;
            bypass_reg      <= 1'b0;
            sample_addr_reg <= '0;
            s1_valid_reg    <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (accept)
            begin
                if (in_data.block_start)
                begin
                    bypass_reg <= start_bypass;
                    if (!start_bypass)
                        line_ptr_reg <= ptr_base + in_data.block_frames;
                end
                if (!item_bypass)
                    sample_addr_reg <= item_addr + 1'b1;
            end
        end
    end

    // mix stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_bypass_reg <= item_bypass;
            s1_addr_reg   <= item_addr;
            s1_live_reg   <= in_data.sample_in;
        end
    end

    // take the write of the previous cycle when it hit the same entry
    assign stored = (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg)) ? fwd_data_reg : rd_data_reg;

    fedl_mix u_mix (
        .stored (stored),
        .live   (s1_live_reg),
        .fb     (fb_eff),
        .mix    (mix)
    );

    assign s1_result.sample_out = s1_bypass_reg ? s1_live_reg : stored;
    assign s1_result.bypassed   = s1_bypass_reg;

    // write port: clearing pass, then write-back
    assign clear_done = clear_cnt_reg[fedl_pkg::ADDR_W];

    always_comb
    begin
        if (!clear_done)
        begin
            wr_en   = 1'b1;
            wr_addr = clear_cnt_reg[fedl_pkg::ADDR_W-1:0];
            wr_data = '0;
        end
        else
        begin
            wr_en   = s1_valid_reg && !s1_bypass_reg;
            wr_addr = s1_addr_reg;
            wr_data = mix;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_cnt_reg <= '0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            if (!clear_done)
                clear_cnt_reg <= clear_cnt_reg + 1'b1;
            fwd_valid_reg <= wr_en;
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_addr_reg <= wr_addr;
        fwd_data_reg <= wr_data;
    end

    // delay line memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
            line_mem[wr_addr] <= wr_data;
        if (accept)
            rd_data_reg <= line_mem[item_addr];
    end

    // result buffer and input flow control
    fedl_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s1_valid_reg),
        .push_data (s1_result),
        .pop       (out_ready),
        .pop_data  (out_data),
        .not_empty (out_valid),
        .count     (fifo_count)
    );

    assign inflight = {1'b0, fifo_count} + (fedl_pkg::FIFO_CNT_W + 1)'(s1_valid_reg);
    assign in_ready = clear_done
                   && (inflight < (fedl_pkg::FIFO_CNT_W + 1)'(fedl_pkg::FIFO_DEPTH));

    // checks
    a_no_item_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> clear_done)
        else $error("item in mix stage during clearing pass");

    a_buffer_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !(out_valid && out_ready)
        |-> fifo_count < fedl_pkg::FIFO_CNT_W'(fedl_pkg::FIFO_DEPTH))
        else $error("result buffer overflow");

    a_writeback_forwarded: assert property (@(posedge clk) disable iff (!rst_n)
        clear_done && s1_valid_reg && !s1_bypass_reg
        |=> fwd_valid_reg && (fwd_addr_reg == $past(s1_addr_reg)))
        else $error("write-back not captured for forwarding");

endmodule

[tb/tb_feedback_echo_delay_line_core.sv]
import fedl_pkg::*;

// mirror of the echo line: predicts each result and holds the ones still due
class echo_line_mirror;
    sample_t             line_copy [LINE_DEPTH];
    int unsigned         frame_ptr;
    logic [ADDR_W-1:0]   sample_addr;
    bit                  pass_through;
    logic [FRAMES_W-1:0] delay_frames;
    logic [CHCFG_W-1:0]  channels;
    logic [FB_W-1:0]     feedback;
    out_item_t           pending_echoes [$];
    int                  mismatches;

    function new();
        foreach (line_copy[i]) line_copy[i] = '0;
        frame_ptr    = 0;
        sample_addr  = '0;
        pass_through = 1'b0;
        delay_frames = FRAMES_W'(4096);
        channels     = CHCFG_W'(1);
        feedback     = FB_W'(64);
        mismatches   = 0;
    endfunction

    function void set_reg(reg_index_t idx, logic [APB_DATA_W-1:0] value);
        case (idx)
            REG_DELAY_FRAMES:    delay_frames = value[FRAMES_W-1:0];
            REG_CHANNEL_COUNT:   channels     = value[CHCFG_W-1:0];
            REG_FEEDBACK_FACTOR: feedback     = value[FB_W-1:0];
            default: ;
        endcase
    endfunction

    // zero counts as one channel, anything above the maximum saturates
    function int eff_channels();
        if (channels == 0)
            return 1;
        if (channels > MAX_CHANNELS)
            return MAX_CHANNELS;
        return int'(channels);
    endfunction

    function int outstanding();
        return pending_echoes.size();
    endfunction

    // one accepted request: block decision, read old entry, mix new entry in
    function void note_request(in_item_t req);
        int        fb;
        int        ch;
        int        stored;
        int        mix;
        out_item_t echo;
        fb = (feedback > WEIGHT_ONE) ? int'(WEIGHT_ONE) : int'(feedback);
        ch = eff_channels();

        // decision made once per block
        if (req.block_start)
        begin
            if (fb == 0 || req.block_frames > delay_frames)
                pass_through = 1'b1;
            else
            begin
                pass_through = 1'b0;
                if (frame_ptr + req.block_frames > delay_frames)
                    frame_ptr = 0;
                sample_addr = ADDR_W'(frame_ptr * ch);
                frame_ptr   = frame_ptr + req.block_frames;
            end
        end

        if (pass_through)
        begin
            echo.sample_out = req.sample_in;
            echo.bypassed   = 1'b1;
        end
        else
        begin
            stored = line_copy[sample_addr];
            mix = (stored * fb + $signed(req.sample_in) * (int'(WEIGHT_ONE) - fb))
                  / int'(WEIGHT_ONE);
            if (mix > int'(SAMPLE_MAX))
                mix = int'(SAMPLE_MAX);
            else if (mix < int'(SAMPLE_MIN))
                mix = int'(SAMPLE_MIN);
            line_copy[sample_addr] = sample_t'(mix);
            sample_addr = sample_addr + 1'b1;
            echo.sample_out = sample_t'(stored);
            echo.bypassed   = 1'b0;
        end
        pending_echoes.push_back(echo);
    endfunction

    // compare one accepted result with the oldest prediction
    function void check_result(out_item_t got);
        out_item_t want;
        if (pending_echoes.size() == 0)
        begin
            $display("%0t: unexpected result sample_out %0d bypassed %0b",
                     $time, got.sample_out, got.bypassed);
            mismatches++;
            return;
        end
        want = pending_echoes.pop_front();
        if (got.sample_out !== want.sample_out)
        begin
            $display("%0t: sample_out expected %0d got %0d",
                     $time, want.sample_out, got.sample_out);
            mismatches++;
        end
        if (got.bypassed !== want.bypassed)
        begin
            $display("%0t: bypassed expected %0b got %0b",
                     $time, want.bypassed, got.bypassed);
            mismatches++;
        end
    endfunction
endclass

module tb_feedback_echo_delay_line_core;

    localparam int STALL_LIMIT = 40000;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    in_item_t              in_data;
    logic                  out_valid;
    logic                  out_ready;
    out_item_t             out_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    bit                    in_calm;
    bit                    out_calm;
    int                    stall_cycles;
    int                    random_items;
    echo_line_mirror       mirror;

    feedback_echo_delay_line_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // watchdog on cycles with no transfer of any kind
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // one sample request, with a random gap ahead of it
    task automatic push_sample(input sample_t s, input logic start,
                               input logic [FRAMES_W-1:0] frames);
        in_item_t req;
        int       gap;
        req.sample_in    = s;
        req.block_start  = start;
        req.block_frames = frames;
        gap = in_calm ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge clk); while (!in_ready);
        mirror.note_request(req);
    endtask

    // register write: setup cycle, access cycle, then the bus returns to idle
    task automatic write_reg(input reg_index_t idx, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(4 * int'(idx));
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        mirror.set_reg(idx, value);
        @(posedge clk);
    endtask

    // stop sending and wait for every predicted result
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (mirror.outstanding() != 0) @(posedge clk);
    endtask

    // result side: random stall per result, then check
    initial
    begin
        int gap;
        out_ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            gap = out_calm ? 0 : $urandom_range(0, 7);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            mirror.check_result(out_data);
        end
    end

    // stimulus
    initial
    begin
        int                  target;
        int                  count;
        int                  n;
        int                  k;
        logic [FRAMES_W-1:0] frames;
        logic [FRAMES_W-1:0] df_pick;
        logic [FB_W-1:0]     fb_pick;
        logic [31:0]         hi;
        sample_t             s;
        bit                  loose;

        mirror       = new();
        random_items = 0;
        in_calm      = 1'b0;
        out_calm     = 1'b0;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_data  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: samples ahead of any block start come from address 0
        push_sample(SAMPLE_MAX, 1'b0, 14'h3fff);
        push_sample(SAMPLE_MIN, 1'b0, 14'h0000);
        push_sample(sample_t'(0), 1'b0, 14'h2aaa);
        // short block reading back what was just written
        push_sample(sample_t'(16'h1234), 1'b1, 14'd2);
        push_sample(sample_t'(-1), 1'b0, 14'h1555);
        push_sample(sample_t'(16'h5555), 1'b0, 14'd0);
        // block longer than the delay passes through
        push_sample(sample_t'(16'haaaa), 1'b1, 14'h3fff);
        push_sample(SAMPLE_MAX, 1'b0, 14'd0);
        // empty block is still processed at the current pointer
        push_sample(SAMPLE_MIN, 1'b1, 14'd0);
        push_sample(sample_t'(100), 1'b0, 14'd0);
        // more samples than the block holds
        push_sample(sample_t'(7), 1'b1, 14'd1);
        push_sample(sample_t'(-8), 1'b0, 14'd0);
        push_sample(sample_t'(9), 1'b0, 14'd0);
        drain();

        // zero feedback bypasses, zero channels, shortest delay
        write_reg(REG_FEEDBACK_FACTOR, 32'd0);
        write_reg(REG_CHANNEL_COUNT, 32'd0);
        write_reg(REG_DELAY_FRAMES, 32'd1);
        push_sample(sample_t'(-12345), 1'b1, 14'd1);
        push_sample(sample_t'(12345), 1'b0, 14'd0);
        drain();

        // feedback above full scale saturates
        write_reg(REG_FEEDBACK_FACTOR, 32'd255);
        push_sample(SAMPLE_MAX, 1'b1, 14'd1);
        push_sample(SAMPLE_MIN, 1'b0, 14'd0);
        push_sample(sample_t'(321), 1'b1, 14'd2);
        drain();

        // delay of 8192 frames, channel count above maximum, pointer rewinds and wraps
        write_reg(REG_DELAY_FRAMES, 32'd8192);
        write_reg(REG_CHANNEL_COUNT, 32'd3);
        write_reg(REG_FEEDBACK_FACTOR, 32'd1);
        push_sample(sample_t'(1000), 1'b1, 14'd5000);
        push_sample(sample_t'(-1000), 1'b1, 14'd4000);
        push_sample(sample_t'(2000), 1'b0, 14'd0);
        push_sample(sample_t'(-2000), 1'b1, 14'd3000);
        push_sample(SAMPLE_MAX, 1'b1, 14'd1192);
        push_sample(SAMPLE_MIN, 1'b0, 14'd0);
        push_sample(sample_t'(55), 1'b1, 14'd1);
        push_sample(sample_t'(-55), 1'b1, 14'd8192);

        // random settings, each followed by a run of blocks
        while (random_items < 1750)
        begin
            drain();
            case ($urandom_range(0, 7))
                0:       df_pick = FRAMES_W'(1);
                1:       df_pick = FRAMES_W'(8192);
                2:       df_pick = $urandom_range(0, 1) ? FRAMES_W'(0) : FRAMES_W'(16383);
                3, 4, 5: df_pick = FRAMES_W'($urandom_range(1, 16));
                default: df_pick = FRAMES_W'($urandom_range(1, 8192));
            endcase
            case ($urandom_range(0, 9))
                0:       fb_pick = FB_W'(0);
                1:       fb_pick = FB_W'(128);
                2:       fb_pick = FB_W'($urandom_range(129, 255));
                3:       fb_pick = FB_W'(1);
                default: fb_pick = FB_W'($urandom_range(1, 127));
            endcase
            hi = $urandom_range(0, 1) ? $urandom : 32'd0;
            write_reg(REG_DELAY_FRAMES, (hi << FRAMES_W) | 32'(df_pick));
            hi = $urandom_range(0, 1) ? $urandom : 32'd0;
            write_reg(REG_CHANNEL_COUNT, (hi << CHCFG_W) | 32'($urandom_range(0, 3)));
            hi = $urandom_range(0, 1) ? $urandom : 32'd0;
            write_reg(REG_FEEDBACK_FACTOR, (hi << FB_W) | 32'(fb_pick));
            in_calm  = ($urandom_range(0, 3) == 0);
            out_calm = ($urandom_range(0, 3) == 0);

            target = $urandom_range(80, 200);
            count  = 0;
            while (count < target)
            begin
                // block length: mostly short, some filling the line or too long
                case ($urandom_range(0, 9))
                    0:       frames = '0;
                    1:       frames = FRAMES_W'($urandom_range(0, 16383));
                    2:       frames = FRAMES_W'(mirror.delay_frames + $urandom_range(1, 3));
                    3:       frames = FRAMES_W'($urandom_range(1, mirror.delay_frames));
                    default: frames = FRAMES_W'($urandom_range(1, 8));
                endcase
                n = frames * mirror.eff_channels();
                if (n == 0 || n > 24)
                    n = $urandom_range(1, 24);
                if ($urandom_range(0, 7) == 0)
                    n = $urandom_range(1, n + 3);
                loose = ($urandom_range(0, 15) == 0);

                for (k = 0; k < n; k++)
                begin
                    if ($urandom_range(0, 7) == 0)
                        s = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
                    else
                        s = sample_t'($urandom);
                    if (k == 0 && !loose)
                        push_sample(s, 1'b1, frames);
                    else
                        push_sample(s, 1'b0, FRAMES_W'($urandom_range(0, 16383)));
                end
                count += n;
            end
            random_items += count;
        end

        // wind down
        drain();
        repeat (16) @(posedge clk);
        if (mirror.mismatches == 0 && mirror.outstanding() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
